// ===== hw/rtl/det_pkg.sv =====
// det_pkg: shared types, codes and constants of the directory entry table.
// Used by det_store and directory_entry_table; depends on nothing.
package det_pkg;

    // Geometry of the directory block
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
    localparam int POS_W   = $clog2(ENTRIES + 1);

    // Operation codes; codes 6 and 7 are ignored
    typedef enum logic [2:0] {
        OP_OPEN      = 3'd0,
        OP_CLOSE     = 3'd1,
        OP_CREATE    = 3'd2,
        OP_DELETE    = 3'd3,
        OP_READ_NEXT = 3'd4,
        OP_REWIND    = 3'd5
    } op_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_OPEN  = 3'd1,
        ST_BAD_NAME  = 3'd2,
        ST_EXISTS    = 3'd3,
        ST_NO_SPACE  = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_END       = 3'd6
    } status_t;

    // Sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    // Input transaction
    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] entry_name;
        logic [15:0] inode_number;
    } request_t;

    // Result transaction
    typedef struct packed {
        status_t     status;
        logic [3:0]  slot_index;
        logic [31:0] found_name;
        logic [15:0] found_inode;
    } result_t;

    // Write command from the sequencer to the slot store
    typedef struct packed {
        logic             en;
        logic             fill;
        logic [IDX_W-1:0] addr;
        logic [31:0]      name;
        logic [15:0]      inode;
    } store_wr_t;

    // Registered read data of the slot store
    typedef struct packed {
        logic        used;
        logic [31:0] name;
        logic [15:0] inode;
    } store_rd_t;

    // Cut the name at its first zero byte
    function automatic logic [31:0] normalize_name(input logic [31:0] n);
        logic [31:0] keep;
        logic        alive;
        keep  = '0;
        alive = 1'b1;
        for (int b = 0; b < 4; b++) begin
            if (n[8*b +: 8] == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                keep[8*b +: 8] = n[8*b +: 8];
            end
        end
        return keep;
    endfunction

endpackage

// ===== hw/rtl/det_store.sv =====
// det_store: slot memory (name and inode) with per-slot used bits.
// Depends on det_pkg. One write and one registered read per cycle.
module det_store (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [det_pkg::IDX_W-1:0] rd_addr,
    input  det_pkg::store_wr_t  wr,
    output det_pkg::store_rd_t  rd
);

    logic [47:0]             mem [det_pkg::ENTRIES];
    logic [det_pkg::ENTRIES-1:0] used_reg;
    logic [47:0]             rd_data_reg;
    logic                    rd_used_reg;

    // Used bits: cleared at reset, set by fill, dropped by clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (wr.en)
        begin
            used_reg[wr.addr] <= wr.fill;
        end
    end

    // Write slot contents on fill
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.fill)
        begin
            mem[wr.addr] <= {wr.name, wr.inode};
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_used_reg <= used_reg[rd_addr];
        end
    end

    assign rd.used  = rd_used_reg;
    assign rd.name  = rd_data_reg[47:16];
    assign rd.inode = rd_data_reg[15:0];

endmodule

// ===== hw/rtl/directory_entry_table.sv =====
// directory_entry_table: top level, operation sequencer and result register.
// Depends on det_pkg and det_store.
//
//   channel   | ports                  | handshake
//   ----------+------------------------+----------------------------------
//   command   | start, busy, request   | taken when start && !busy
//   result    | done, result           | one cycle per transaction, no stall
//
// Open, close, rewind, rejected and unused operations answer in the cycle after
// acceptance and leave busy low. Create, delete and read_next scan the slot
// memory one slot per cycle through its single, registered read port, and
// stop early on a match. Reset clears the used bits at once; no clearing
// pass is needed.
// The receiver cannot stall, so each result is shown exactly once.
module directory_entry_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  det_pkg::request_t request,
    output logic              done,
    output det_pkg::result_t  result
);

    localparam logic [det_pkg::IDX_W-1:0] LAST_IDX = det_pkg::IDX_W'(det_pkg::ENTRIES - 1);
    localparam logic [det_pkg::POS_W-1:0] END_POS  = det_pkg::POS_W'(det_pkg::ENTRIES);

    det_pkg::state_t               state_reg, state_next;
    det_pkg::op_t                  op_reg, op_next;
    logic [31:0]                   name_reg, name_next;
    logic [15:0]                   inode_reg, inode_next;
    logic [det_pkg::POS_W-1:0]     addr_reg, addr_next;
    logic [det_pkg::IDX_W-1:0]     chk_reg, chk_next;
    logic                          chk_vld_reg, chk_vld_next;
    logic                          free_fnd_reg, free_fnd_next;
    logic [det_pkg::IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic                          is_open_reg, is_open_next;
    logic [det_pkg::POS_W-1:0]     rpos_reg, rpos_next;
    det_pkg::result_t              result_reg, result_next;
    logic                          done_reg, done_next;

    logic                          rd_en;
    logic [det_pkg::IDX_W-1:0]     rd_addr;
    det_pkg::store_wr_t            wr;
    det_pkg::store_rd_t            rd;
    logic [31:0]                   req_name;
    logic                          accept;
    logic                          name_hit;
    logic                          last;

    det_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr      (wr),
        .rd      (rd)
    );

    assign accept   = start && (state_reg == det_pkg::S_IDLE);
    assign req_name = det_pkg::normalize_name(request.entry_name);
    assign busy     = (state_reg != det_pkg::S_IDLE);
    assign done     = done_reg;
    assign result   = result_reg;

    // Issue one slot read per cycle while scanning
    assign rd_en    = (state_reg == det_pkg::S_SCAN) && (addr_reg < END_POS);
    assign rd_addr  = addr_reg[det_pkg::IDX_W-1:0];
    assign name_hit = rd.used && (rd.name == name_reg);
    assign last     = (chk_reg == LAST_IDX);

    // Next state, scan evaluation and result
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        name_next     = name_reg;
        inode_next    = inode_reg;
        addr_next     = addr_reg;
        chk_next      = rd_addr;
        chk_vld_next  = rd_en;
        free_fnd_next = free_fnd_reg;
        free_idx_next = free_idx_reg;
        is_open_next  = is_open_reg;
        rpos_next     = rpos_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        wr            = '0;
        wr.name       = name_reg;
        wr.inode      = inode_reg;

        if (rd_en)
        begin
            addr_next = addr_reg + 1'b1;
        end

        case (state_reg)
            det_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = det_pkg::op_t'(request.operation);
                    name_next     = req_name;
                    inode_next    = request.inode_number;
                    free_fnd_next = 1'b0;
                    addr_next     = '0;
                    result_next   = '0;
                    result_next.status = det_pkg::ST_OK;
                    done_next     = 1'b1;
                    case (det_pkg::op_t'(request.operation))
                        det_pkg::OP_OPEN:
                        begin
                            if (req_name == 32'd0)
                            begin
                                result_next.status = det_pkg::ST_BAD_NAME;
                            end
                            else
                            begin
                                is_open_next = 1'b1;
                                rpos_next    = '0;
                            end
                        end
                        det_pkg::OP_CLOSE:
                        begin
                            if (req_name == 32'd0)
                            begin
                                result_next.status = det_pkg::ST_BAD_NAME;
                            end
                            else if (!is_open_reg)
                            begin
                                result_next.status = det_pkg::ST_NOT_OPEN;
                            end
                            else
                            begin
                                is_open_next = 1'b0;
                                rpos_next    = '0;
                            end
                        end
                        det_pkg::OP_CREATE, det_pkg::OP_DELETE:
                        begin
                            if (!is_open_reg)
                            begin
                                result_next.status = det_pkg::ST_NOT_OPEN;
                            end
                            else if (req_name == 32'd0)
                            begin
                                result_next.status = det_pkg::ST_BAD_NAME;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = det_pkg::S_SCAN;
                            end
                        end
                        det_pkg::OP_READ_NEXT:
                        begin
                            if (!is_open_reg)
                            begin
                                result_next.status = det_pkg::ST_NOT_OPEN;
                            end
                            else if (rpos_reg >= END_POS)
                            begin
                                result_next.status = det_pkg::ST_END;
                                rpos_next          = END_POS;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                addr_next  = rpos_reg;
                                state_next = det_pkg::S_SCAN;
                            end
                        end
                        det_pkg::OP_REWIND:
                        begin
                            if (!is_open_reg)
                            begin
                                result_next.status = det_pkg::ST_NOT_OPEN;
                            end
                            else
                            begin
                                rpos_next = '0;
                            end
                        end
                        default:
                        begin
                            result_next.status = det_pkg::ST_OK;
                        end
                    endcase
                end
            end

            det_pkg::S_SCAN:
            begin
                if (chk_vld_reg)
                begin
                    case (op_reg)
                        det_pkg::OP_CREATE:
                        begin
                            if (name_hit)
                            begin
                                result_next.status = det_pkg::ST_EXISTS;
                                done_next          = 1'b1;
                            end
                            else if (last)
                            begin
                                done_next = 1'b1;
                                if (free_fnd_reg || !rd.used)
                                begin
                                    wr.en   = 1'b1;
                                    wr.fill = 1'b1;
                                    wr.addr = free_fnd_reg ? free_idx_reg : chk_reg;
                                    result_next.slot_index = 4'(wr.addr);
                                end
                                else
                                begin
                                    result_next.status = det_pkg::ST_NO_SPACE;
                                end
                            end
                            else if (!free_fnd_reg && !rd.used)
                            begin
                                free_fnd_next = 1'b1;
                                free_idx_next = chk_reg;
                            end
                        end
                        det_pkg::OP_DELETE:
                        begin
                            if (name_hit)
                            begin
                                wr.en   = 1'b1;
                                wr.addr = chk_reg;
                                result_next.slot_index  = 4'(chk_reg);
                                result_next.found_inode = rd.inode;
                                done_next = 1'b1;
                            end
                            else if (last)
                            begin
                                result_next.status = det_pkg::ST_NOT_FOUND;
                                done_next          = 1'b1;
                            end
                        end
                        det_pkg::OP_READ_NEXT:
                        begin
                            if (rd.used)
                            begin
                                result_next.slot_index  = 4'(chk_reg);
                                result_next.found_name  = rd.name;
                                result_next.found_inode = rd.inode;
                                rpos_next = det_pkg::POS_W'(chk_reg) + 1'b1;
                                done_next = 1'b1;
                            end
                            else if (last)
                            begin
                                result_next.status = det_pkg::ST_END;
                                rpos_next          = END_POS;
                                done_next          = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                    if (done_next)
                    begin
                        state_next = det_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = det_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= det_pkg::S_IDLE;
            chk_vld_reg <= 1'b0;
            is_open_reg <= 1'b0;
            rpos_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            is_open_reg <= is_open_next;
            rpos_reg    <= rpos_next;
            done_reg    <= done_next;
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        name_reg     <= name_next;
        inode_reg    <= inode_next;
        addr_reg     <= addr_next;
        chk_reg      <= chk_next;
        free_fnd_reg <= free_fnd_next;
        free_idx_reg <= free_idx_next;
        result_reg   <= result_next;
    end

    // A result strobe always returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy)
        else $error("result strobe while busy");

    // Every accepted transaction either answers or starts a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done_reg || state_reg == det_pkg::S_SCAN))
        else $error("accepted transaction went nowhere");

    // Read position never passes the end of the block
    assert property (@(posedge clk) disable iff (!rst_n) rpos_reg <= END_POS)
        else $error("read position out of range");

    // A closed directory keeps its read position at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        !is_open_reg |-> (rpos_reg == '0))
        else $error("read position moved while closed");

endmodule
